@@ hw/rtl/gtha_pkg.sv @@
package gtha_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned IDX_W    = 16;
  localparam int unsigned GEN_W    = 16;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned CFG_W    = 11;

  // Operation codes carried in the request payload.
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // Status codes returned with every response.
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_SLOT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic commit;
    logic clear;
  } gtha_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reinit;
    logic clear_last;
    logic out_free;
  } gtha_sts_t;

endpackage

@@ hw/rtl/gtha_req_if.sv @@
interface gtha_req_if
  import gtha_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, output op, output handle, input ready);
  modport sink   (input valid, input op, input handle, output ready);
endinterface

@@ hw/rtl/gtha_rsp_if.sv @@
interface gtha_rsp_if
  import gtha_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STAT_W-1:0]   status;
  logic [HANDLE_W-1:0] result_handle;

  modport source (output valid, output status, output result_handle, input ready);
  modport sink   (input valid, input status, input result_handle, output ready);
endinterface

@@ hw/rtl/generation_tagged_handle_allocator.sv @@
// A result is loaded into the output register in EXEC, the state that follows
// its request transaction, once the previous result is taken from that register.
// A new request is not taken until the previous one has been written back, set
// by the read-then-write of the single-port queue and slot-table memories.
// Reset and every nonzero slot_count write start a clearing sweep of the whole
// slot table, during which no request is accepted.
// Reset is asynchronous and active low; it restores slot_count to MAX_SLOTS.
module generation_tagged_handle_allocator
  import gtha_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  gtha_req_if.sink         req,
  gtha_rsp_if.source       rsp,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  // The controller sequences each request through two phases. In IDLE it takes
  // the request transaction and the datapath launches reads of both queue heads
  // and of the slot named by the handle. In EXEC the datapath decides the
  // outcome, writes the queues and the slot table, and loads the output
  // register. EXEC waits only while the output register still holds a result
  // that the sink has not taken.
  gtha_cmd_t cmd;
  gtha_sts_t sts;

  gtha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath owns the two index queues, the slot table with its occupied
  // flag and generation, the generation counter and the output register.
  // Queue A starts out holding the indices in order; that content is produced
  // from its head pointer until the queue first runs dry, so it needs no fill.
  gtha_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_op_i      (req.op),
    .in_handle_i  (req.handle),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (rsp.valid),
    .out_ready_i  (rsp.ready),
    .out_status_o (rsp.status),
    .out_handle_o (rsp.result_handle)
  );

`ifndef NO_ASSERTIONS
  // A result may only be loaded when the previous one is gone or leaving.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!rsp.valid || rsp.ready))
    else $error("result register overwritten before it was taken");

  // The block drops ready once it has taken a request, so requests are never taken back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken in back-to-back cycles");

  // A new result only appears after a commit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp.valid) |-> $past(cmd.commit))
    else $error("result appeared without a commit");

  // No request is taken while the slot table is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> !req.ready)
    else $error("request taken during the clearing sweep");
`endif

endmodule

@@ hw/rtl/gtha_ctrl.sv @@
module gtha_ctrl
  import gtha_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  gtha_sts_t sts_i,
  output gtha_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    CLEARING,
    IDLE,
    EXEC
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CLEARING;
    end else if (sts_i.reinit) begin
      state_q <= CLEARING;
    end else begin
      unique case (state_q)
        CLEARING: if (sts_i.clear_last) state_q <= IDLE;
        IDLE:     if (in_valid_i) state_q <= EXEC;
        EXEC:     if (sts_i.out_free) state_q <= IDLE;
        default:  state_q <= CLEARING;
      endcase
    end
  end

  // The request is taken only in IDLE; the result is written back in EXEC
  // once the output register can take it.
  assign in_ready_o    = (state_q == IDLE);
  assign cmd_o.accept  = (state_q == IDLE) && in_valid_i;
  assign cmd_o.commit  = (state_q == EXEC) && sts_i.out_free;
  assign cmd_o.clear   = (state_q == CLEARING);

endmodule

@@ hw/rtl/gtha_dp.sv @@
module gtha_dp
  import gtha_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gtha_cmd_t           cmd_i,
  output gtha_sts_t           sts_o,
  input  logic [OP_W-1:0]     in_op_i,
  input  logic [HANDLE_W-1:0] in_handle_i,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STAT_W-1:0]   out_status_o,
  output logic [HANDLE_W-1:0] out_handle_o
);

  localparam int unsigned AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned PW = CW + 1;
  localparam int unsigned SW = GEN_W + 1;

  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_SLOTS - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_SLOTS);

  // Index queues and slot table ({occupied, generation}).
  logic [AW-1:0] qa_mem [MAX_SLOTS];
  logic [AW-1:0] qb_mem [MAX_SLOTS];
  logic [SW-1:0] slot_mem [MAX_SLOTS];

  logic [AW-1:0]    qa_rd_q, qb_rd_q;
  logic [SW-1:0]    slot_rd_q;
  logic [OP_W-1:0]  op_q;
  logic [IDX_W-1:0] idx_q;

  logic [AW-1:0]    head_a_q, head_a_d, head_b_q, head_b_d;
  logic [CW-1:0]    cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic             act_b_q, act_b_d;
  logic             a_init_q, a_init_d;
  logic [GEN_W-1:0] gen_q, gen_d;
  logic [CW-1:0]    slot_count_q;
  logic [AW-1:0]    clr_addr_q;

  logic                out_valid_q;
  logic [STAT_W-1:0]   out_status_q, out_status_d;
  logic [HANDLE_W-1:0] out_handle_q, out_handle_d;

  logic             cfg_hit;
  logic [CW-1:0]    cfg_count;

  logic             swap, new_b, in_range, occupied;
  logic [GEN_W-1:0] gen_new;
  logic [CW-1:0]    pop_cnt;
  logic [AW-1:0]    pop_val;
  logic [AW-1:0]    push_pos;
  logic [PW-1:0]    push_sum;
  logic             push_ok;

  logic             slot_we;
  logic [AW-1:0]    slot_waddr;
  logic [SW-1:0]    slot_wdata;
  logic             qa_we, qb_we;

  // A zero write is ignored; anything above the table size saturates.
  assign cfg_hit   = cfg_we_i && (cfg_wdata_i != '0);
  assign cfg_count = (32'(cfg_wdata_i) > 32'(MAX_SLOTS)) ? FULL_CNT : CW'(cfg_wdata_i);

  assign sts_o.reinit     = cfg_hit;
  assign sts_o.clear_last = (clr_addr_q == LAST_ADDR);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign in_range = 32'(idx_q) < 32'(slot_count_q);
  assign occupied = slot_rd_q[SW-1];

  // Allocation path: swap queues when the active one has run dry.
  assign swap    = act_b_q ? (cnt_b_q == '0) : (cnt_a_q == '0);
  assign new_b   = act_b_q ^ swap;
  assign gen_new = gen_q + GEN_W'(swap);
  assign pop_cnt = new_b ? cnt_b_q : cnt_a_q;
  // Until queue A first runs dry, its entry at the head is the head itself.
  assign pop_val = new_b ? qb_rd_q : (a_init_q ? head_a_q : qa_rd_q);

  // Free path: push onto the queue that is not active.
  assign push_sum = act_b_q ? (PW'(head_a_q) + PW'(cnt_a_q))
                            : (PW'(head_b_q) + PW'(cnt_b_q));
  assign push_pos = (push_sum >= PW'(MAX_SLOTS)) ? AW'(push_sum - PW'(MAX_SLOTS))
                                                 : AW'(push_sum);
  assign push_ok  = act_b_q ? (cnt_a_q != FULL_CNT) : (cnt_b_q != FULL_CNT);

  always_comb begin
    head_a_d     = head_a_q;
    head_b_d     = head_b_q;
    cnt_a_d      = cnt_a_q;
    cnt_b_d      = cnt_b_q;
    act_b_d      = act_b_q;
    a_init_d     = a_init_q;
    gen_d        = gen_q;
    out_status_d = STAT_OK;
    out_handle_d = '0;
    slot_we      = 1'b0;
    slot_waddr   = clr_addr_q;
    slot_wdata   = '0;
    qa_we        = 1'b0;
    qb_we        = 1'b0;

    if (cmd_i.clear) begin
      slot_we = 1'b1;
    end else if (cmd_i.commit) begin
      case (op_q)
        OP_ALLOC: begin
          act_b_d = new_b;
          gen_d   = gen_new;
          if (swap && !act_b_q) begin
            a_init_d = 1'b0;
          end
          if (pop_cnt == '0) begin
            out_status_d = STAT_NO_SLOT;
          end else begin
            if (new_b) begin
              head_b_d = (head_b_q == LAST_ADDR) ? '0 : head_b_q + 1'b1;
              cnt_b_d  = cnt_b_q - 1'b1;
            end else begin
              head_a_d = (head_a_q == LAST_ADDR) ? '0 : head_a_q + 1'b1;
              cnt_a_d  = cnt_a_q - 1'b1;
            end
            slot_we      = 1'b1;
            slot_waddr   = pop_val;
            slot_wdata   = {1'b1, gen_new};
            out_handle_d = {gen_new, IDX_W'(pop_val)};
          end
        end
        OP_FREE: begin
          if (!in_range) begin
            out_status_d = STAT_RANGE;
          end else if (!occupied) begin
            out_status_d = STAT_EMPTY;
          end else begin
            slot_we    = 1'b1;
            slot_waddr = idx_q[AW-1:0];
            slot_wdata = {1'b0, slot_rd_q[GEN_W-1:0]};
            if (push_ok) begin
              if (act_b_q) begin
                qa_we   = 1'b1;
                cnt_a_d = cnt_a_q + 1'b1;
              end else begin
                qb_we   = 1'b1;
                cnt_b_d = cnt_b_q + 1'b1;
              end
            end
          end
        end
        OP_LOOKUP: begin
          if (!in_range) begin
            out_status_d = STAT_RANGE;
          end else if (!occupied) begin
            out_status_d = STAT_EMPTY;
          end else begin
            out_handle_d = {slot_rd_q[GEN_W-1:0], idx_q};
          end
        end
        default: out_status_d = STAT_RANGE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_a_q     <= '0;
      head_b_q     <= '0;
      cnt_a_q      <= FULL_CNT;
      cnt_b_q      <= '0;
      act_b_q      <= 1'b0;
      a_init_q     <= 1'b1;
      gen_q        <= '0;
      slot_count_q <= FULL_CNT;
      clr_addr_q   <= '0;
    end else if (cfg_hit) begin
      head_a_q     <= '0;
      head_b_q     <= '0;
      cnt_a_q      <= cfg_count;
      cnt_b_q      <= '0;
      act_b_q      <= 1'b0;
      a_init_q     <= 1'b1;
      gen_q        <= '0;
      slot_count_q <= cfg_count;
      clr_addr_q   <= '0;
    end else begin
      head_a_q <= head_a_d;
      head_b_q <= head_b_d;
      cnt_a_q  <= cnt_a_d;
      cnt_b_q  <= cnt_b_d;
      act_b_q  <= act_b_d;
      a_init_q <= a_init_d;
      gen_q    <= gen_d;
      if (cmd_i.clear && !sts_o.clear_last) begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_status_q <= out_status_d;
      out_handle_q <= out_handle_d;
    end
    if (cmd_i.accept) begin
      op_q  <= in_op_i;
      idx_q <= in_handle_i[IDX_W-1:0];
    end
  end

  // Memory reads are issued with the request; writes land in EXEC or the sweep.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      qa_rd_q   <= qa_mem[head_a_q];
      qb_rd_q   <= qb_mem[head_b_q];
      slot_rd_q <= slot_mem[in_handle_i[AW-1:0]];
    end
    if (qa_we) begin
      qa_mem[push_pos] <= idx_q[AW-1:0];
    end
    if (qb_we) begin
      qb_mem[push_pos] <= idx_q[AW-1:0];
    end
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_handle_o = out_handle_q;

endmodule
